FILE: rtl/lutds_pkg.sv
// shared types and constants of the lu task dependency scheduler
`timescale 1ns / 1ps

package lutds_pkg;

  // input word modes
  localparam logic [1:0] MODE_FETCH       = 2'd0;
  localparam logic [1:0] MODE_PANEL_DONE  = 2'd1;
  localparam logic [1:0] MODE_UPDATE_DONE = 2'd2;
  localparam logic [1:0] MODE_RESTART     = 2'd3;

  // result word kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_PANEL  = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // table read address select
  localparam logic [1:0] RD_LAST = 2'd0;
  localparam logic [1:0] RD_P    = 2'd1;
  localparam logic [1:0] RD_U    = 2'd2;

  localparam int LEVEL_W = 8;            // level, two's complement, -1 means not started
  localparam int ENTRY_W = LEVEL_W + 1;  // claimed flag on top of the level
  localparam int CMP_W   = 10;           // width for level compares
  localparam int COL_W   = 6;            // column fields of the words
  localparam int CFG_W   = 7;            // num_columns register

  localparam logic [1:0] REG_NUM_COLUMNS = 2'd0;

  typedef struct packed {
    logic       out_load;
    logic [1:0] out_kind;
    logic       p_clr;
    logic       p_inc;
    logic       u_load;
    logic       u_inc;
    logic [1:0] rd_sel;
    logic       claim_p;
    logic       claim_u;
    logic       done_wr;
    logic       clear_all;
  } lutds_cmd_t;

  typedef struct packed {
    logic ent_free;
    logic eq_last;
    logic eq_p;
    logic eq_pm1;
    logic p_more;
    logic u_more;
    logic out_free;
  } lutds_stat_t;

endpackage

FILE: rtl/lutds_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module lutds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lutds_ctrl.sv
// sequencer of the scheduler: end check, panel scan and update scan
`timescale 1ns / 1ps

module lutds_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            in_mode,
  output logic                  in_ready,
  input  lutds_pkg::lutds_stat_t stat,
  output lutds_pkg::lutds_cmd_t  cmd
);
  import lutds_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_E_RD  = 3'd1;
  localparam logic [2:0] S_E_CHK = 3'd2;
  localparam logic [2:0] S_P_RD  = 3'd3;
  localparam logic [2:0] S_P_CHK = 3'd4;
  localparam logic [2:0] S_U_RD  = 3'd5;
  localparam logic [2:0] S_U_CHK = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE) && stat.out_free;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_P;
    unique case (state)
      S_IDLE: begin
        if (in_valid && stat.out_free) begin
          unique case (in_mode)
            MODE_FETCH: begin
              state_next = S_E_RD;
            end
            MODE_PANEL_DONE, MODE_UPDATE_DONE: begin
              cmd.done_wr  = 1'b1;
              cmd.out_load = 1'b1;
              cmd.out_kind = KIND_NONE;
            end
            default: begin
              cmd.clear_all = 1'b1;
              cmd.out_load  = 1'b1;
              cmd.out_kind  = KIND_NONE;
            end
          endcase
        end
      end
      S_E_RD: begin
        cmd.rd_sel = RD_LAST;
        cmd.p_clr  = 1'b1;
        state_next = S_E_CHK;
      end
      S_E_CHK: begin
        if (stat.ent_free && stat.eq_last) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_END;
          state_next   = S_IDLE;
        end else begin
          state_next = S_P_RD;
        end
      end
      S_P_RD: begin
        cmd.rd_sel = RD_P;
        state_next = S_P_CHK;
      end
      S_P_CHK: begin
        priority if (stat.ent_free && stat.eq_pm1) begin
          cmd.claim_p  = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_PANEL;
          state_next   = S_IDLE;
        end else if (stat.ent_free && stat.eq_p && stat.p_more) begin
          // panel p finished: look for a column right of it still at p-1
          cmd.u_load = 1'b1;
          state_next = S_U_RD;
        end else if (stat.p_more) begin
          cmd.p_inc  = 1'b1;
          state_next = S_P_RD;
        end else begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_NONE;
          state_next   = S_IDLE;
        end
      end
      S_U_RD: begin
        cmd.rd_sel = RD_U;
        state_next = S_U_CHK;
      end
      S_U_CHK: begin
        priority if (stat.ent_free && stat.eq_pm1) begin
          cmd.claim_u  = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_UPDATE;
          state_next   = S_IDLE;
        end else if (stat.u_more) begin
          cmd.u_inc  = 1'b1;
          state_next = S_U_RD;
        end else if (stat.p_more) begin
          cmd.p_inc  = 1'b1;
          state_next = S_P_RD;
        end else begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_NONE;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/lutds_dp.sv
// datapath of the scheduler: progress table, scan counters, compares, result register
`timescale 1ns / 1ps

module lutds_dp #(
  parameter int MAX_COLUMNS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lutds_pkg::CFG_W-1:0] num_columns,
  input  lutds_pkg::lutds_cmd_t       cmd,
  output lutds_pkg::lutds_stat_t      stat,
  input  logic [1:0]                  in_mode,
  input  logic [lutds_pkg::COL_W-1:0] col_p,
  input  logic [lutds_pkg::COL_W-1:0] col_u,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  task_kind,
  output logic [lutds_pkg::COL_W-1:0] task_p,
  output logic [lutds_pkg::COL_W-1:0] task_u
);
  import lutds_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int NW = CW + 1;

  logic [NW-1:0]          n_act;
  logic [CW-1:0]          p;
  logic [CW-1:0]          u;
  logic [CW-1:0]          last_col;
  logic [CW-1:0]          raddr;
  logic [CW-1:0]          waddr;
  logic [ENTRY_W-1:0]     wdata;
  logic                   we;
  logic [ENTRY_W-1:0]     rdata;
  logic                   rd_vld;
  logic [MAX_COLUMNS-1:0] valid;
  logic [LEVEL_W-1:0]     ent_level;
  logic                   ent_claimed;
  logic [CMP_W-1:0]       lvl_x;
  logic                   done_in_range;
  logic [CW-1:0]          done_addr;
  logic [COL_W-1:0]       done_col;

  // effective column count: 0 acts as 1, clipped to the table depth
  always_comb begin
    if (num_columns == '0) begin
      n_act = NW'(1);
    end else if (int'(num_columns) > MAX_COLUMNS) begin
      n_act = NW'(MAX_COLUMNS);
    end else begin
      n_act = NW'(num_columns);
    end
  end

  assign last_col = CW'(n_act - NW'(1));

  always_comb begin
    unique case (cmd.rd_sel)
      RD_LAST: raddr = last_col;
      RD_U:    raddr = u;
      default: raddr = p;
    endcase
  end

  // completion writes come straight from the input word
  assign done_col      = (in_mode == MODE_PANEL_DONE) ? col_p : col_u;
  assign done_in_range = int'(done_col) < MAX_COLUMNS;
  assign done_addr     = CW'(done_col);

  always_comb begin
    we    = 1'b0;
    waddr = p;
    wdata = {1'b1, ent_level};
    if (cmd.claim_p) begin
      we = 1'b1;
    end else if (cmd.claim_u) begin
      we    = 1'b1;
      waddr = u;
    end else if (cmd.done_wr) begin
      we    = done_in_range;
      waddr = done_addr;
      wdata = {1'b0, LEVEL_W'(col_p)};
    end
  end

  lutds_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_COLUMNS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= valid[raddr];
      if (cmd.clear_all) begin
        valid <= '0;
      end else if (we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  // an entry never written reads as not started and unclaimed
  assign ent_level   = rd_vld ? rdata[LEVEL_W-1:0] : '1;
  assign ent_claimed = rd_vld & rdata[ENTRY_W-1];
  assign lvl_x       = {{(CMP_W-LEVEL_W){ent_level[LEVEL_W-1]}}, ent_level};

  always_ff @(posedge clk) begin
    if (cmd.p_clr) begin
      p <= '0;
    end else if (cmd.p_inc) begin
      p <= p + CW'(1);
    end
    if (cmd.u_load) begin
      u <= p + CW'(1);
    end else if (cmd.u_inc) begin
      u <= u + CW'(1);
    end
  end

  always_comb begin
    stat.ent_free = !ent_claimed;
    stat.eq_last  = lvl_x == CMP_W'(last_col);
    stat.eq_p     = lvl_x == CMP_W'(p);
    stat.eq_pm1   = lvl_x == (CMP_W'(p) - CMP_W'(1));
    stat.p_more   = ({1'b0, p} + NW'(1)) < n_act;
    stat.u_more   = ({1'b0, u} + NW'(1)) < n_act;
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      task_kind <= cmd.out_kind;
      task_p    <= ((cmd.out_kind == KIND_PANEL) || (cmd.out_kind == KIND_UPDATE)) ?
                   COL_W'(p) : '0;
      task_u    <= (cmd.out_kind == KIND_UPDATE) ? COL_W'(u) : '0;
    end
  end

endmodule

FILE: rtl/lu_task_dependency_scheduler.sv
// top level of the lu task dependency scheduler with its register port
`timescale 1ns / 1ps

// Task scheduler for a blocked LU factorization. A progress table holds, per
// block column, the last panel applied to it (not started after reset or a
// restart word) and a claimed flag. A fetch word (tuser 0) first checks the
// last column for its own panel level and answers "finished"; otherwise it
// scans panel columns p from 0 upward, granting a panel task for a column at
// level p-1, or, when column p has its panel done, an update task (p,u) for
// the first column u > p still at level p-1. The granted column is claimed.
// Panel-done and update-done words write the table and clear the claim,
// restart clears the whole table; all three are answered with kind 0.
// Exactly one result word follows each input word. The table lives in a ram
// with one read port and a registered read, so every column visited goes
// through a read state and a check state. One word is worked on at a time;
// a new word is taken once the previous one has its result placed in the
// output register and that register is free or being drained. Per-column
// valid flops stand in for a clearing pass, so there is no wait after reset
// or restart. num_columns sits at byte address 0 of the register port and
// must be changed only while the block is idle.

module lu_task_dependency_scheduler #(
  parameter int MAX_COLUMNS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // col_p [5:0], col_u [11:6], zero [15:12]
  input  logic [1:0]  s_tuser,   // mode [1:0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // task_p [5:0], task_u [11:6], zero [15:12]
  output logic [1:0]  m_tuser,   // task_kind [1:0]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lutds_pkg::*;

  lutds_cmd_t       cmd;
  lutds_stat_t      stat;
  logic [CFG_W-1:0] num_columns;
  logic [COL_W-1:0] task_p;
  logic [COL_W-1:0] task_u;
  logic             cfg_we;

  // register port: always ready, single register at address 0
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr == REG_NUM_COLUMNS);
  assign prdata = (paddr == REG_NUM_COLUMNS) ? {{(32-CFG_W){1'b0}}, num_columns} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_columns <= CFG_W'(64);
    end else if (cfg_we) begin
      num_columns <= pwdata[CFG_W-1:0];
    end
  end

  lutds_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_mode (s_tuser),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  lutds_dp #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .num_columns(num_columns),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (s_tuser),
    .col_p      (s_tdata[5:0]),
    .col_u      (s_tdata[11:6]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .task_kind  (m_tuser),
    .task_p     (task_p),
    .task_u     (task_u)
  );

  // the top nibble of m_tdata is padding
  assign m_tdata = {4'b0000, task_u, task_p};

endmodule
